@@ hdl/dtq_pkg.sv @@
// Shared types and codes for the deadline timer queue.
package dtq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int REL_CNT_W   = $clog2(MAX_RESULTS);

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [1:0] OUT_RELEASED = 2'd0;
  localparam logic [1:0] OUT_READY    = 2'd1;
  localparam logic [1:0] OUT_QUEUED   = 2'd2;
  localparam logic [1:0] OUT_FULL     = 2'd3;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_POP    = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  waiter_id;
    logic [47:0] wake_time;
  } dtq_in_t;

  typedef struct packed {
    logic [7:0] resumed_id;
    logic [1:0] outcome;
    logic       last_of_run;
  } dtq_out_t;

  typedef struct packed {
    logic [1:0] op;
  } dtq_cell_ctrl_t;

endpackage

@@ hdl/dtq_cell.sv @@
// One slot of the sorted waiter chain: holds, takes a new entry, or shifts.
module dtq_cell #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtq_pkg::dtq_cell_ctrl_t ctrl,
  input  logic [TIME_WIDTH-1:0]  new_time,
  input  logic [7:0]             new_id,
  input  logic                   prev_keep,
  input  logic                   prev_valid,
  input  logic [TIME_WIDTH-1:0]  prev_time,
  input  logic [7:0]             prev_id,
  input  logic                   next_valid,
  input  logic [TIME_WIDTH-1:0]  next_time,
  input  logic [7:0]             next_id,
  output logic                   keep,
  output logic                   valid,
  output logic [TIME_WIDTH-1:0]  wake,
  output logic [7:0]             id
);
  import dtq_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [TIME_WIDTH-1:0] time_r, time_nxt;
  logic [7:0]            id_r, id_nxt;

  // Entries due no later than the newcomer stay ahead of it (ties keep arrival order).
  assign keep = valid_r && (time_r <= new_time);

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    id_nxt    = id_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            valid_nxt = 1'b1;
            time_nxt  = new_time;
            id_nxt    = new_id;
          end else begin
            valid_nxt = prev_valid;
            time_nxt  = prev_time;
            id_nxt    = prev_id;
          end
        end
      end
      CELL_POP: begin
        valid_nxt = next_valid;
        time_nxt  = next_time;
        id_nxt    = next_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    time_r <= time_nxt;
    id_r   <= id_nxt;
  end

  assign valid = valid_r;
  assign wake  = time_r;
  assign id    = id_r;

endmodule

@@ hdl/deadline_timer_queue_unit.sv @@
// Deadline timer queue: a chain of sorted cells holding sleeping waiters.
// Sleep beat: busy while in the sleep state; its single result is registered from that state.
// Tick beat: the time counter advances at acceptance; releases follow one per cycle from
//   the head of the chain, each registered before it shows, up to 16 per tick, and busy
//   holds for the whole run, also when nothing is due. Results cannot be stalled.
// Reset (synchronous, rst_n low) empties the chain and zeroes the time counter at once.
module deadline_timer_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int TIME_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dtq_pkg::dtq_in_t  in_data,
  output logic              out_valid,
  output dtq_pkg::dtq_out_t out_data
);
  import dtq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SLEEP = 2'd1;
  localparam logic [1:0] S_REL   = 2'd2;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic [1:0]            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [7:0]            id_r, id_nxt;
  logic [TIME_WIDTH-1:0] wt_r, wt_nxt;
  logic [REL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dtq_out_t              out_data_r, out_data_nxt;
  dtq_cell_ctrl_t        ctrl;

  // Chain taps; index DEPTH is an always-empty sentinel past the tail.
  logic                  c_valid [0:DEPTH];
  logic [TIME_WIDTH-1:0] c_time  [0:DEPTH];
  logic [7:0]            c_id    [0:DEPTH];
  logic                  c_keep  [0:DEPTH-1];

  logic [63:0]           wt_wide;
  logic [TIME_WIDTH-1:0] wt_sat;
  logic                  head_due, next_due, run_end;

  assign c_valid[DEPTH] = 1'b0;
  assign c_time[DEPTH]  = '0;
  assign c_id[DEPTH]    = '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      dtq_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_time   (wt_r),
        .new_id     (id_r),
        .prev_keep  ((g == 0) ? 1'b1 : c_keep[(g == 0) ? 0 : g - 1]),
        .prev_valid ((g == 0) ? 1'b0 : c_valid[(g == 0) ? 0 : g - 1]),
        .prev_time  (c_time[(g == 0) ? 0 : g - 1]),
        .prev_id    (c_id[(g == 0) ? 0 : g - 1]),
        .next_valid (c_valid[g + 1]),
        .next_time  (c_time[g + 1]),
        .next_id    (c_id[g + 1]),
        .keep       (c_keep[g]),
        .valid      (c_valid[g]),
        .wake       (c_time[g]),
        .id         (c_id[g])
      );
    end
  endgenerate

  // Clamp a wake time beyond the counter range to its largest value.
  always_comb begin
    wt_wide = 64'(in_data.wake_time);
    if (wt_wide > 64'(TIME_MAX)) begin
      wt_sat = TIME_MAX;
    end else begin
      wt_sat = wt_wide[TIME_WIDTH-1:0];
    end
  end

  // The head is always the earliest waiter; the one behind it, or the release cap, decides end of run.
  assign head_due = c_valid[0] && (c_time[0] <= now_r);
  assign next_due = c_valid[1] && (c_time[1] <= now_r);
  assign run_end  = (cnt_r == REL_CNT_W'(MAX_RESULTS - 1)) || !next_due;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    id_nxt        = id_r;
    wt_nxt        = wt_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctrl.op       = CELL_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt  = in_data.waiter_id;
          wt_nxt  = wt_sat;
          cnt_nxt = '0;
          if (in_data.req_type == REQ_TICK) begin
            // Advance time now, saturating at the top.
            if (now_r != TIME_MAX) begin
              now_nxt = now_r + TIME_WIDTH'(1);
            end
            state_nxt = S_REL;
          end else begin
            state_nxt = S_SLEEP;
          end
        end
      end
      S_SLEEP: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.resumed_id  = id_r;
        out_data_nxt.last_of_run = 1'b1;
        if (wt_r < now_r) begin
          out_data_nxt.outcome = OUT_READY;
        end else if (c_valid[DEPTH-1]) begin
          out_data_nxt.outcome = OUT_FULL;
        end else begin
          out_data_nxt.outcome = OUT_QUEUED;
          ctrl.op              = CELL_INSERT;
        end
        state_nxt = S_IDLE;
      end
      S_REL: begin
        if (head_due) begin
          // Pop the head and shift the chain up by one.
          ctrl.op                  = CELL_POP;
          out_valid_nxt            = 1'b1;
          out_data_nxt.resumed_id  = c_id[0];
          out_data_nxt.outcome     = OUT_RELEASED;
          out_data_nxt.last_of_run = run_end;
          cnt_nxt                  = cnt_r + REL_CNT_W'(1);
          if (run_end) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    id_r       <= id_nxt;
    wt_r       <= wt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
